>>> hdl/acr_pkg.sv
`timescale 1ns / 1ps
// Shared codes for the adaptive credit regulator: request function codes
// and configuration register indexes. No dependencies.
package acr_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_DONATE = 2'd0;
   localparam logic [1:0] FUNC_BORROW = 2'd1;
   localparam logic [1:0] FUNC_UPDATE = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_POOL_SIZE      = 3'd0;
   localparam logic [2:0] CSR_DAMPING_BETA   = 3'd1;
   localparam logic [2:0] CSR_TARGET_GAIN    = 3'd2;
   localparam logic [2:0] CSR_MEAN_WEIGHT    = 3'd3;
   localparam logic [2:0] CSR_CREDIT_FLOOR   = 3'd4;
   localparam logic [2:0] CSR_CREDIT_CEILING = 3'd5;
   localparam logic [2:0] CSR_WINDOW_TICKS   = 3'd6;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

endpackage

>>> hdl/adaptive_credit_regulator.sv
`timescale 1ns / 1ps
// Adaptive credit regulator top level: slot table, history ring memory and
// the shared shift-add / shift-subtract unit with its sequencer. Uses acr_pkg.

// The block keeps, for each slot, saturating donation and borrowing sums with
// seen flags and a ring of up to HIST_DEPTH timestamped credit samples. After
// reset it clears the slot table and holds req_stall high meanwhile;
// configuration writes are taken at any time. A donation or borrowing request
// reads the slot, adds and writes back. An update request examines ring
// entries for expiry and sums the entries left in the ring; when both sums of
// the slot have been seen, it also computes the donation ratio after right
// shifts that bring both sums below 2^47. Most of an update's time is spent in
// the single 72-bit add/subtract unit, which performs every multiplication one
// multiplier bit per cycle (five of them) and every division one quotient bit
// per cycle, and in the ring walk, which reads the history memory through its
// one read port. Only one request is in work at a time: req_stall is low only
// while the sequencer is idle. The result sits in an output register, so the
// next request is taken while a finished result still waits on rsp_stall.
module adaptive_credit_regulator #(
   parameter int unsigned SLOTS      = 64,
   parameter int unsigned HIST_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_func,
   input  logic [5:0]                        req_slot,
   input  logic [31:0]                       req_amount,
   input  logic [31:0]                       req_credit,
   input  logic [31:0]                       req_now,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [5:0]                        rsp_out_slot,
   output logic [31:0]                       rsp_new_credit,
   input  logic                              csr_write,
   input  logic [acr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [acr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import acr_pkg::*;

   localparam int unsigned SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned PW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int unsigned CW   = $clog2(HIST_DEPTH + 1);
   localparam int unsigned HD   = SLOTS * HIST_DEPTH;
   localparam int unsigned HAW  = (HD > 1) ? $clog2(HD) : 1;
   localparam int unsigned SUMW = 32 + CW;
   localparam logic [PW-1:0] DEPTH_M1 = PW'(HIST_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(HIST_DEPTH);
   localparam logic [SW-1:0] SLOT_M1  = SW'(SLOTS - 1);

   typedef struct packed {
      logic [63:0]   dsum;
      logic [63:0]   bsum;
      logic          dseen;
      logic          bseen;
      logic [PW-1:0] head;
      logic [CW-1:0] cnt;
   } slot_word_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_SRD, S_SDAT, S_XRD, S_XCHK, S_MWR, S_VRD, S_VACC,
      S_MEAN, S_RUN, S_U1, S_U2, S_RAT, S_NORM, S_RDIV, S_RGET, S_A, S_T,
      S_D, S_FIN, S_OUT
   } state_type;

   typedef enum logic {OP_MUL, OP_DIV} op_type;

   // Configuration registers.
   logic [15:0] beta_ff, gain_ff;
   logic [16:0] hw_ff;
   logic [31:0] floor_ff, ceil_ff, window_ff;

   // Sequencer and request registers.
   state_type      state_ff, ret_ff;
   op_type         op_ff;
   logic [1:0]     func_ff;
   logic [5:0]     slot_ff;
   logic [31:0]    amount_ff, credit_ff, now_ff;
   logic [PW-1:0]  head_ff, pos_ff;
   logic [CW-1:0]  cnt_ff, k_ff;
   logic [SUMW-1:0] sum_ff;
   logic [63:0]    d_ff, b_ff;
   logic           dseen_ff, bseen_ff;
   logic [SW-1:0]  clr_ff;

   // Shared unit registers.
   logic [71:0]    acc_ff, mc_ff;
   logic [16:0]    mr_ff;
   logic [63:0]    qd_ff;
   logic [6:0]     n_ff;
   logic [47:0]    u_ff;
   logic [15:0]    r_ff;
   logic           up_ff;
   logic [39:0]    c_ff;

   // Output register.
   logic           rsp_valid_ff;
   logic [5:0]     rsp_slot_ff;
   logic [31:0]    rsp_credit_ff;

   // Memories.
   slot_word_type  smem [SLOTS];
   slot_word_type  smem_rd_ff;
   logic [63:0]    hmem [HD];
   logic [63:0]    hmem_rd_ff;

   slot_word_type  smem_wd;
   logic           smem_we;
   logic [SW-1:0]  smem_wa;
   logic           hmem_we;
   logic [HAW-1:0] hmem_wa, hmem_ra, base;
   logic [SW-1:0]  slot_idx;

   // Ring bookkeeping for the push.
   logic [PW-1:0]  h1, wpos;
   logic [CW-1:0]  c1;
   logic [CW:0]    pos_sum;

   // Record path.
   logic [64:0]    rec_ext;
   logic [63:0]    rec_new;

   // Shared adder.
   logic [71:0]    div_x, add_x, add_y;
   logic [72:0]    add_s;

   // Arithmetic helpers.
   logic [16:0]    w;
   logic [44:0]    t_val, c8;
   logic [63:0]    mag, c24, res;
   logic [31:0]    cl, cl2;
   logic [31:0]    age;

   function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p);
      return (p == DEPTH_M1) ? '0 : p + 1'b1;
   endfunction

   assign slot_idx = SW'(slot_ff);
   assign base     = HAW'(slot_idx * HIST_DEPTH);

   always_comb begin
      // Make room when the ring is full, then find the slot for the new sample.
      if (smem_rd_ff.cnt >= DEPTH_C) begin
         h1 = pos_next(smem_rd_ff.head);
         c1 = DEPTH_C - 1'b1;
      end else begin
         h1 = smem_rd_ff.head;
         c1 = smem_rd_ff.cnt;
      end
      pos_sum = (CW + 1)'(h1) + (CW + 1)'(c1);
      if (pos_sum >= (CW + 1)'(HIST_DEPTH)) begin
         wpos = PW'(pos_sum - (CW + 1)'(HIST_DEPTH));
      end else begin
         wpos = PW'(pos_sum);
      end
   end

   always_comb begin
      rec_ext = (func_ff == FUNC_DONATE) ? {1'b0, smem_rd_ff.dsum} : {1'b0, smem_rd_ff.bsum};
      rec_ext = rec_ext + {33'd0, amount_ff};
      rec_new = rec_ext[64] ? '1 : rec_ext[63:0];
   end

   always_comb begin
      smem_we = 1'b0;
      smem_wa = slot_idx;
      smem_wd = smem_rd_ff;
      unique case (state_ff)
         S_CLEAR: begin
            smem_we = 1'b1;
            smem_wa = clr_ff;
            smem_wd = '0;
         end
         S_SDAT: begin
            if (func_ff == FUNC_DONATE) begin
               smem_we       = 1'b1;
               smem_wd.dsum  = rec_new;
               smem_wd.dseen = 1'b1;
            end else if (func_ff == FUNC_BORROW) begin
               smem_we       = 1'b1;
               smem_wd.bsum  = rec_new;
               smem_wd.bseen = 1'b1;
            end
         end
         S_MWR: begin
            smem_we = 1'b1;
            smem_wd = '{dsum: d_ff, bsum: b_ff, dseen: dseen_ff, bseen: bseen_ff,
                        head: head_ff, cnt: cnt_ff};
         end
         default: begin
         end
      endcase
   end

   assign hmem_we = (state_ff == S_SDAT) && (func_ff == FUNC_UPDATE);
   assign hmem_wa = base + HAW'(wpos);
   assign hmem_ra = base + HAW'(pos_ff);

   always_ff @(posedge clock) begin
      if (smem_we) begin
         smem[smem_wa] <= smem_wd;
      end
      smem_rd_ff <= smem[slot_idx];
   end

   // History word: time stamp in the upper half, credit sample in the lower.
   always_ff @(posedge clock) begin
      if (hmem_we) begin
         hmem[hmem_wa] <= {now_ff, credit_ff};
      end
      hmem_rd_ff <= hmem[hmem_ra];
   end

   // The one adder: accumulate for multiply steps, trial subtract for divide steps.
   always_comb begin
      div_x = {acc_ff[70:0], qd_ff[63]};
      if (op_ff == OP_DIV) begin
         add_x = div_x;
         add_y = ~mc_ff;
      end else begin
         add_x = acc_ff;
         add_y = mr_ff[0] ? mc_ff : '0;
      end
      add_s = {1'b0, add_x} + {1'b0, add_y} + 73'(op_ff == OP_DIV);
   end

   always_comb begin
      w     = (hw_ff > 17'h10000) ? 17'h10000 : hw_ff;
      t_val = acc_ff[68:24];
      c8    = 45'({credit_ff, 8'd0});
      mag   = acc_ff[63:0];
      c24   = 64'({credit_ff, 24'd0});
      res   = up_ff ? c24 + mag : c24 - mag;
      cl    = (c_ff > 40'(ceil_ff)) ? ceil_ff : c_ff[31:0];
      cl2   = (cl < floor_ff) ? floor_ff : cl;
      age   = now_ff - hmem_rd_ff[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff   <= 16'd32768;
         gain_ff   <= 16'd4096;
         hw_ff     <= 17'd32768;
         floor_ff  <= 32'd0;
         ceil_ff   <= 32'hFFFF_FFFF;
         window_ff <= 32'd3600;
      end else if (csr_write) begin
         unique case (csr_index)
            // The pool size cancels out of the target, so nothing is stored.
            CSR_POOL_SIZE:      begin
            end
            CSR_DAMPING_BETA:   beta_ff   <= csr_data[15:0];
            CSR_TARGET_GAIN:    gain_ff   <= csr_data[15:0];
            CSR_MEAN_WEIGHT:    hw_ff     <= csr_data[16:0];
            CSR_CREDIT_FLOOR:   floor_ff  <= csr_data;
            CSR_CREDIT_CEILING: ceil_ff   <= csr_data;
            CSR_WINDOW_TICKS:   window_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_IDLE;
         op_ff        <= OP_MUL;
         clr_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In S_OUT the output register is handled by the state itself.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SLOT_M1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  func_ff   <= req_func;
                  slot_ff   <= req_slot;
                  amount_ff <= req_amount;
                  credit_ff <= req_credit;
                  now_ff    <= req_now;
                  // Unknown functions and slots past the table are dropped here.
                  if ((req_func == FUNC_DONATE || req_func == FUNC_BORROW ||
                       req_func == FUNC_UPDATE) && (32'(req_slot) < SLOTS)) begin
                     state_ff <= S_SRD;
                  end
               end
            end
            S_SRD: state_ff <= S_SDAT;
            S_SDAT: begin
               if (func_ff == FUNC_UPDATE) begin
                  head_ff  <= h1;
                  pos_ff   <= h1;
                  cnt_ff   <= c1 + 1'b1;
                  d_ff     <= smem_rd_ff.dsum;
                  b_ff     <= smem_rd_ff.bsum;
                  dseen_ff <= smem_rd_ff.dseen;
                  bseen_ff <= smem_rd_ff.bseen;
                  state_ff <= S_XRD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_XRD: state_ff <= S_XCHK;
            S_XCHK: begin
               // The newest sample has age zero, so this always stops with one left.
               if ((cnt_ff != '0) && (age > window_ff)) begin
                  head_ff  <= pos_next(head_ff);
                  pos_ff   <= pos_next(head_ff);
                  cnt_ff   <= cnt_ff - 1'b1;
                  state_ff <= S_XRD;
               end else begin
                  state_ff <= S_MWR;
               end
            end
            S_MWR: begin
               pos_ff   <= head_ff;
               k_ff     <= '0;
               sum_ff   <= '0;
               state_ff <= S_VRD;
            end
            S_VRD: begin
               state_ff <= (k_ff == cnt_ff) ? S_MEAN : S_VACC;
            end
            S_VACC: begin
               sum_ff   <= sum_ff + SUMW'(hmem_rd_ff[31:0]);
               pos_ff   <= pos_next(pos_ff);
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_VRD;
            end
            S_MEAN: begin
               qd_ff    <= 64'({sum_ff, 16'd0});
               mc_ff    <= 72'(cnt_ff);
               acc_ff   <= '0;
               op_ff    <= OP_DIV;
               n_ff     <= 7'd64;
               ret_ff   <= S_U1;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               n_ff <= n_ff - 1'b1;
               if (op_ff == OP_DIV) begin
                  if (add_s[72]) begin
                     acc_ff <= add_s[71:0];
                     qd_ff  <= {qd_ff[62:0], 1'b1};
                  end else begin
                     acc_ff <= div_x;
                     qd_ff  <= {qd_ff[62:0], 1'b0};
                  end
               end else begin
                  acc_ff <= add_s[71:0];
                  mc_ff  <= {mc_ff[70:0], 1'b0};
                  mr_ff  <= {1'b0, mr_ff[16:1]};
               end
               if (n_ff == 7'd1) begin
                  state_ff <= ret_ff;
               end
            end
            S_U1: begin
               // Weighted mean, first term: w times the ring mean.
               mc_ff    <= 72'(qd_ff);
               mr_ff    <= w;
               acc_ff   <= '0;
               op_ff    <= OP_MUL;
               n_ff     <= 7'd17;
               ret_ff   <= S_U2;
               state_ff <= S_RUN;
            end
            S_U2: begin
               // Second term adds onto the first.
               mc_ff    <= 72'({credit_ff, 16'd0});
               mr_ff    <= 17'h10000 - w;
               n_ff     <= 7'd17;
               ret_ff   <= S_RAT;
               state_ff <= S_RUN;
            end
            S_RAT: begin
               u_ff <= acc_ff[63:16];
               if (dseen_ff && bseen_ff) begin
                  state_ff <= S_NORM;
               end else begin
                  r_ff     <= 16'h8000;
                  state_ff <= S_A;
               end
            end
            S_NORM: begin
               if ((|d_ff[63:47]) || (|b_ff[63:47])) begin
                  d_ff <= {1'b0, d_ff[63:1]};
                  b_ff <= {1'b0, b_ff[63:1]};
               end else begin
                  state_ff <= S_RDIV;
               end
            end
            S_RDIV: begin
               qd_ff    <= {d_ff[47:0], 16'd0};
               mc_ff    <= 72'(d_ff + b_ff + 64'd1);
               acc_ff   <= '0;
               op_ff    <= OP_DIV;
               n_ff     <= 7'd64;
               ret_ff   <= S_RGET;
               state_ff <= S_RUN;
            end
            S_RGET: begin
               r_ff     <= qd_ff[15:0];
               state_ff <= S_A;
            end
            S_A: begin
               mc_ff    <= 72'(u_ff);
               mr_ff    <= {1'b0, gain_ff};
               acc_ff   <= '0;
               op_ff    <= OP_MUL;
               n_ff     <= 7'd17;
               ret_ff   <= S_T;
               state_ff <= S_RUN;
            end
            S_T: begin
               // a = u*gain >> 12, then times (1 + ratio) in Q.16.
               mc_ff    <= 72'(acc_ff[63:12]);
               mr_ff    <= 17'h10000 + 17'(r_ff);
               acc_ff   <= '0;
               n_ff     <= 7'd17;
               ret_ff   <= S_D;
               state_ff <= S_RUN;
            end
            S_D: begin
               up_ff    <= (t_val >= c8);
               mc_ff    <= 72'((t_val >= c8) ? t_val - c8 : c8 - t_val);
               mr_ff    <= {1'b0, beta_ff};
               acc_ff   <= '0;
               n_ff     <= 7'd17;
               ret_ff   <= S_FIN;
               state_ff <= S_RUN;
            end
            S_FIN: begin
               // A step below zero lands on the floor; zero does that through the clamp.
               if (!up_ff && (mag > c24)) begin
                  c_ff <= '0;
               end else begin
                  c_ff <= res[63:24];
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_slot_ff   <= slot_ff;
                  rsp_credit_ff <= cl2;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_slot   = rsp_slot_ff;
   assign rsp_new_credit = rsp_credit_ff;

endmodule

>>> hdl/acr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the adaptive credit regulator and the bind that
// attaches them. Uses acr_pkg and the adaptive_credit_regulator ports.
module acr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [1:0]                        req_func,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [5:0]                        rsp_out_slot,
   input logic [31:0]                       rsp_new_credit
);
   import acr_pkg::*;

   // A result waiting on the consumer holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_credit) &&
                                 $stable(rsp_out_slot))
      else $error("result changed while stalled");

   // The slot table is being cleared right after reset.
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during table clear");

   // A valid update or record keeps the block busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == FUNC_UPDATE || req_func == FUNC_DONATE ||
      req_func == FUNC_BORROW) |=> req_stall)
      else $error("block not busy after a request");

   // No result can appear the cycle after a request is taken.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind adaptive_credit_regulator acr_checker u_acr_checker (.*);
